@@ sv/skt_pkg.sv @@
`timescale 1ns / 1ps

package skt_pkg;

   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 32;
   localparam int COUNT_W   = 7;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_DUP       = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_COMPARE,
      FSM_REDUCE1,
      FSM_REDUCE2,
      FSM_APPLY
   } fsm_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic                 cmp;
      logic                 ins;
      logic                 del;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } cell_ctrl_type;

endpackage

@@ sv/skt_if.sv @@
`timescale 1ns / 1ps

interface skt_req_if;
   logic                          valid;
   logic                          ready;
   skt_pkg::op_type               op;
   logic signed [skt_pkg::KEY_W-1:0] key;
   logic [skt_pkg::PAYLOAD_W-1:0] payload;

   modport source (output valid, output op, output key, output payload, input ready);
   modport sink   (input valid, input op, input key, input payload, output ready);
endinterface

interface skt_rsp_if;
   logic                          valid;
   logic                          ready;
   skt_pkg::status_type           status;
   logic [skt_pkg::PAYLOAD_W-1:0] found_payload;
   logic [skt_pkg::COUNT_W-1:0]   entry_count;
   logic                          is_empty;

   modport source (output valid, output status, output found_payload,
                   output entry_count, output is_empty, input ready);
   modport sink   (input valid, input status, input found_payload,
                   input entry_count, input is_empty, output ready);
endinterface

@@ sv/skt_cell.sv @@
`timescale 1ns / 1ps

module skt_cell (
   input  logic                          clock,
   input  skt_pkg::cell_ctrl_type        ctrl,
   input  logic                          occupied,
   input  logic [skt_pkg::KEY_W-1:0]     left_key,
   input  logic [skt_pkg::PAYLOAD_W-1:0] left_payload,
   input  logic                          left_less,
   input  logic [skt_pkg::KEY_W-1:0]     right_key,
   input  logic [skt_pkg::PAYLOAD_W-1:0] right_payload,
   output logic [skt_pkg::KEY_W-1:0]     stored_key,
   output logic [skt_pkg::PAYLOAD_W-1:0] stored_payload,
   output logic                          less,
   output logic                          equal
);
   import skt_pkg::*;

   logic [KEY_W-1:0]     key_ff, key_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;
   logic                 less_ff, less_in;
   logic                 equal_ff, equal_in;

   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      less_in    = less_ff;
      equal_in   = equal_ff;
      if (ctrl.cmp) begin
         less_in  = occupied && ($signed(key_ff) < $signed(ctrl.key));
         equal_in = occupied && (key_ff == ctrl.key);
      end
      // cells below the insert point keep, the first one at or above takes the new entry
      if (ctrl.ins && !less_ff) begin
         if (left_less) begin
            key_in     = ctrl.key;
            payload_in = ctrl.payload;
         end else begin
            key_in     = left_key;
            payload_in = left_payload;
         end
      end else if (ctrl.del && !less_ff) begin
         key_in     = right_key;
         payload_in = right_payload;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
      less_ff    <= less_in;
      equal_ff   <= equal_in;
   end

   assign stored_key     = key_ff;
   assign stored_payload = payload_ff;
   assign less           = less_ff;
   assign equal          = equal_ff;

endmodule

@@ sv/skt_reduce.sv @@
`timescale 1ns / 1ps

module skt_reduce #(
   parameter int N = 32
) (
   input  logic                                 clock,
   input  logic [N-1:0]                         hit_vec,
   input  logic [N-1:0][skt_pkg::PAYLOAD_W-1:0] data_vec,
   output logic                                 hit,
   output logic [skt_pkg::PAYLOAD_W-1:0]        data
);
   import skt_pkg::*;

   logic                 hit_ff, hit_in;
   logic [PAYLOAD_W-1:0] data_ff, data_in;

   // keys are unique, so at most one input is hit and an or picks its data
   always_comb begin
      hit_in  = 1'b0;
      data_in = '0;
      for (int i = 0; i < N; i++) begin
         hit_in  = hit_in | hit_vec[i];
         data_in = data_in | (data_vec[i] & {PAYLOAD_W{hit_vec[i]}});
      end
   end

   always_ff @(posedge clock) begin
      hit_ff  <= hit_in;
      data_ff <= data_in;
   end

   assign hit  = hit_ff;
   assign data = data_ff;

endmodule

@@ sv/sorted_key_table_top.sv @@
`timescale 1ns / 1ps

// Sorted key table: up to CAPACITY entries of signed key and payload kept in
// ascending key order in a chain of cells, with insert, delete, search and
// clear requests. Each request runs from one accepted beat to the next
// through capture, a compare in every cell against the broadcast key, the
// registered match tree (groups of 32 cells, then one level over the
// groups), and an apply step in which, on an insert or delete, the cells
// at or above the key's place shift. The result is held in an output register, so
// a new request is taken while the previous result still waits; the shift
// step waits only when that register is still occupied. No clearing pass.
module sorted_key_table_top #(
   parameter int CAPACITY = 64
) (
   input  logic      clock,
   input  logic      reset,
   skt_req_if.sink   req_bus,
   skt_rsp_if.source rsp_bus
);
   import skt_pkg::*;

   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int GROUP   = 32;
   localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;
   localparam int PAD     = NGROUPS * GROUP;

   fsm_type              state_ff, state_in;
   op_type               op_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [PAYLOAD_W-1:0] payload_ff;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [PAYLOAD_W-1:0] rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_empty_ff, rsp_empty_in;

   cell_ctrl_type        ctrl;
   logic                 accept;

   logic [CAPACITY-1:0]                occ;
   logic [CAPACITY-1:0][KEY_W-1:0]     cell_key;
   logic [CAPACITY-1:0][PAYLOAD_W-1:0] cell_payload;
   logic [CAPACITY-1:0]                cell_less;
   logic [CAPACITY-1:0]                cell_equal;

   logic [PAD-1:0]                     eq_pad;
   logic [PAD-1:0][PAYLOAD_W-1:0]      pay_pad;
   logic [NGROUPS-1:0]                 grp_hit;
   logic [NGROUPS-1:0][PAYLOAD_W-1:0]  grp_data;
   logic                               hit;
   logic [PAYLOAD_W-1:0]               found;
   logic [CNT_W+COUNT_W-1:0]           count_wide;

   assign accept = req_bus.valid && req_bus.ready;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [KEY_W-1:0]     lkey;
         logic [PAYLOAD_W-1:0] lpay;
         logic                 lless;
         logic [KEY_W-1:0]     rkey;
         logic [PAYLOAD_W-1:0] rpay;

         assign occ[g] = CNT_W'(g) < count_ff;

         if (g == 0) begin : g_head
            assign lkey  = ctrl.key;
            assign lpay  = ctrl.payload;
            assign lless = 1'b1;
         end else begin : g_body
            assign lkey  = cell_key[g-1];
            assign lpay  = cell_payload[g-1];
            assign lless = cell_less[g-1];
         end

         if (g == CAPACITY - 1) begin : g_tail
            assign rkey = cell_key[g];
            assign rpay = cell_payload[g];
         end else begin : g_mid
            assign rkey = cell_key[g+1];
            assign rpay = cell_payload[g+1];
         end

         skt_cell u_cell (
            .clock          (clock),
            .ctrl           (ctrl),
            .occupied       (occ[g]),
            .left_key       (lkey),
            .left_payload   (lpay),
            .left_less      (lless),
            .right_key      (rkey),
            .right_payload  (rpay),
            .stored_key     (cell_key[g]),
            .stored_payload (cell_payload[g]),
            .less           (cell_less[g]),
            .equal          (cell_equal[g])
         );
      end

      for (g = 0; g < PAD; g++) begin : g_pad
         if (g < CAPACITY) begin : g_real
            assign eq_pad[g]  = cell_equal[g];
            assign pay_pad[g] = cell_payload[g];
         end else begin : g_zero
            assign eq_pad[g]  = 1'b0;
            assign pay_pad[g] = '0;
         end
      end

      for (g = 0; g < NGROUPS; g++) begin : g_grp
         skt_reduce #(.N(GROUP)) u_grp (
            .clock    (clock),
            .hit_vec  (eq_pad[g*GROUP +: GROUP]),
            .data_vec (pay_pad[g*GROUP +: GROUP]),
            .hit      (grp_hit[g]),
            .data     (grp_data[g])
         );
      end
   endgenerate

   skt_reduce #(.N(NGROUPS)) u_final (
      .clock    (clock),
      .hit_vec  (grp_hit),
      .data_vec (grp_data),
      .hit      (hit),
      .data     (found)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      ctrl.cmp      = 1'b0;
      ctrl.ins      = 1'b0;
      ctrl.del      = 1'b0;
      ctrl.key      = key_ff;
      ctrl.payload  = payload_ff;

      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) state_in = FSM_COMPARE;
         end
         FSM_COMPARE: begin
            ctrl.cmp = 1'b1;
            state_in = FSM_REDUCE1;
         end
         FSM_REDUCE1: state_in = FSM_REDUCE2;
         FSM_REDUCE2: state_in = FSM_APPLY;
         FSM_APPLY: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in      = FSM_IDLE;
               rsp_status_in = ST_DONE;
               rsp_found_in  = '0;
               unique case (op_ff)
                  OP_INSERT: begin
                     if (hit) begin
                        rsp_status_in = ST_DUP;
                     end else if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctrl.ins = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_DELETE: begin
                     if (!hit) begin
                        rsp_status_in = ST_NOT_FOUND;
                     end else begin
                        ctrl.del = 1'b1;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_SEARCH: begin
                     if (!hit) rsp_status_in = ST_NOT_FOUND;
                     else rsp_found_in = found;
                  end
                  OP_CLEAR: count_in = '0;
                  default: ;
               endcase
               rsp_valid_in = 1'b1;
               rsp_empty_in = (count_in == '0);
               count_wide   = {{COUNT_W{1'b0}}, count_in};
               rsp_count_in = count_wide[COUNT_W-1:0];
            end
         end
         default: state_in = FSM_IDLE;
      endcase
      count_wide = {{COUNT_W{1'b0}}, count_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_bus.op;
         key_ff     <= req_bus.key;
         payload_ff <= req_bus.payload;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign req_bus.ready         = (state_ff == FSM_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.found_payload = rsp_found_ff;
   assign rsp_bus.entry_count   = rsp_count_ff;
   assign rsp_bus.is_empty      = rsp_empty_ff;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import skt_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int POOL_MAX    = 96;
   localparam int RANDOM_ITEMS = 650;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AFTER  = 120;
   localparam int STALL_LIMIT = 5000;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      status_type           status;
      logic [PAYLOAD_W-1:0] found_payload;
      logic [COUNT_W-1:0]   entry_count;
      logic                 is_empty;
   } reply_type;

   // mirror of the ordered table, predicts one reply per request beat
   class table_scoreboard_type;
      logic signed [KEY_W-1:0] key_at [TABLE_DEPTH];
      logic [PAYLOAD_W-1:0]    payload_at [TABLE_DEPTH];
      int unsigned             fill;
      reply_type               expected_replies[$];
      int unsigned             failures;
      int unsigned             requests_seen;

      function new();
         fill = 0;
         failures = 0;
         requests_seen = 0;
      endfunction

      function void note_request(op_type op, logic signed [KEY_W-1:0] key,
                                 logic [PAYLOAD_W-1:0] payload);
         int unsigned pos;
         int unsigned i;
         bit hit;
         reply_type r;
         pos = 0;
         while (pos < fill && key_at[pos] < key) pos++;
         hit = (pos < fill) && (key_at[pos] == key);
         r.status = ST_DONE;
         r.found_payload = '0;
         case (op)
            OP_INSERT: begin
               // duplicate wins over full
               if (hit) r.status = ST_DUP;
               else if (fill >= TABLE_DEPTH) r.status = ST_FULL;
               else begin
                  for (i = fill; i > pos; i--) begin
                     key_at[i] = key_at[i-1];
                     payload_at[i] = payload_at[i-1];
                  end
                  key_at[pos] = key;
                  payload_at[pos] = payload;
                  fill++;
               end
            end
            OP_DELETE: begin
               if (!hit) r.status = ST_NOT_FOUND;
               else begin
                  for (i = pos; i + 1 < fill; i++) begin
                     key_at[i] = key_at[i+1];
                     payload_at[i] = payload_at[i+1];
                  end
                  fill--;
               end
            end
            OP_SEARCH: begin
               if (!hit) r.status = ST_NOT_FOUND;
               else r.found_payload = payload_at[pos];
            end
            default: fill = 0;
         endcase
         r.entry_count = COUNT_W'(fill);
         r.is_empty = (fill == 0);
         expected_replies.push_back(r);
         requests_seen++;
      endfunction

      function void check_reply(reply_type got);
         reply_type want;
         if (expected_replies.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: reply beat with nothing outstanding: status %0d payload %h",
                        $realtime, got.status, got.found_payload,
                        " count %0d empty %0d", got.entry_count, got.is_empty);
            return;
         end
         want = expected_replies.pop_front();
         if (got.status !== want.status || got.found_payload !== want.found_payload ||
             got.entry_count !== want.entry_count || got.is_empty !== want.is_empty) begin
            failures++;
            if (failures <= 10)
               $display("%0t: reply mismatch exp status %0d payload %h count %0d empty %0d,",
                        $realtime, want.status, want.found_payload, want.entry_count,
                        want.is_empty,
                        " got status %0d payload %h count %0d empty %0d",
                        got.status, got.found_payload, got.entry_count, got.is_empty);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   sender_steady = 1'b0;

   skt_req_if req_bus ();
   skt_rsp_if rsp_bus ();

   table_scoreboard_type tracker = new();

   sorted_key_table_top #(.CAPACITY(TABLE_DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #10 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int unsigned idle_span();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   task automatic send_request(input op_type op, input logic signed [KEY_W-1:0] key,
                               input logic [PAYLOAD_W-1:0] payload);
      int unsigned gap;
      gap = sender_steady ? 0 : idle_span();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.op      <= op;
      req_bus.key     <= key;
      req_bus.payload <= payload;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            tracker.note_request(req_bus.op, req_bus.key, req_bus.payload);
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.check_reply({rsp_bus.status, rsp_bus.found_payload,
                                 rsp_bus.entry_count, rsp_bus.is_empty});
      end
   end

   initial begin : reply_sink
      bit held_off;
      int unsigned stall;
      held_off = 1'b0;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && tracker.requests_seen >= HOLD_OFF_AFTER) begin
            // long back-pressure so the table stops taking requests
            held_off = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            stall = idle_span();
            if (stall != 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(40, 80)) @(posedge clock);
         else repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin : request_source
      logic signed [KEY_W-1:0] pool [POOL_MAX];
      logic signed [KEY_W-1:0] base;
      logic signed [KEY_W-1:0] swap_key;
      logic signed [KEY_W-1:0] pick;
      int unsigned sent;
      int unsigned pool_size;
      int unsigned style;
      int unsigned run_len;
      int unsigned j;
      int unsigned k;
      int unsigned r;
      bit big_run;
      bit insert_heavy;
      op_type op;

      req_bus.valid   <= 1'b0;
      req_bus.op      <= OP_INSERT;
      req_bus.key     <= '0;
      req_bus.payload <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extreme keys, sign boundary, duplicates, absent keys
      send_request(OP_SEARCH, 32'sd0, 32'hFFFF_FFFF);
      send_request(OP_DELETE, 32'sd5, 32'h0);
      send_request(OP_CLEAR, 32'sd0, 32'h0);
      send_request(OP_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'sh8000_0000, 32'h0000_0000);
      send_request(OP_INSERT, 32'sd0, 32'hA5A5_A5A5);
      send_request(OP_INSERT, -32'sd1, 32'h5A5A_5A5A);
      send_request(OP_INSERT, 32'sd1, 32'h0000_0001);
      send_request(OP_INSERT, 32'sd0, 32'h1234_5678);
      send_request(OP_SEARCH, 32'sh8000_0000, 32'hFFFF_FFFF);
      send_request(OP_SEARCH, 32'sh7FFF_FFFF, 32'h0);
      send_request(OP_SEARCH, -32'sd1, 32'h0);
      send_request(OP_SEARCH, 32'sd2, 32'h0);
      send_request(OP_DELETE, 32'sd0, 32'hFFFF_FFFF);
      send_request(OP_DELETE, 32'sd0, 32'h0);
      send_request(OP_SEARCH, 32'sd0, 32'h0);
      send_request(OP_DELETE, 32'sh7FFF_FFFF, 32'h0);
      send_request(OP_DELETE, 32'sh8000_0000, 32'h0);
      send_request(OP_SEARCH, 32'sd1, 32'h0);
      send_request(OP_CLEAR, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_SEARCH, -32'sd1, 32'h0);
      send_request(OP_INSERT, -32'sd1, 32'hDEAD_BEEF);
      send_request(OP_DELETE, -32'sd1, 32'h0);

      sent = 0;
      big_run = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         sender_steady = ($urandom_range(0, 4) == 0);
         pool_size = big_run ? POOL_MAX : $urandom_range(4, 40);
         style = $urandom_range(0, 2);
         case (style)
            0: base = 32'sd0;
            1: base = -$signed(pool_size / 2);
            default: base = 32'sh7FFF_FFFF - $signed(pool_size / 2);
         endcase
         // sequential pools placed near the most positive key wrap into the most negative
         for (j = 0; j < pool_size; j++)
            pool[j] = (style == 0) ? $signed($urandom) : base + $signed(j);
         for (j = pool_size - 1; j > 0; j--) begin
            k = $urandom_range(0, j);
            swap_key = pool[j];
            pool[j] = pool[k];
            pool[k] = swap_key;
         end
         if (big_run) begin
            // more distinct keys than slots, so the table ends up full
            for (j = 0; j < 70; j++) begin
               send_request(OP_INSERT, pool[j], $urandom);
               sent++;
            end
         end
         insert_heavy = big_run || ($urandom_range(0, 2) == 0);
         run_len = big_run ? 60 : $urandom_range(10, 40);
         for (j = 0; j < run_len; j++) begin
            r = $urandom_range(0, 99);
            if (r < 2) op = OP_CLEAR;
            else if (r < (insert_heavy ? 70 : 40)) op = OP_INSERT;
            else if (r < (insert_heavy ? 85 : 70)) op = OP_SEARCH;
            else op = OP_DELETE;
            pick = ($urandom_range(0, 9) == 0) ? $signed($urandom)
                                               : pool[$urandom_range(0, pool_size - 1)];
            send_request(op, pick, $urandom);
            sent++;
         end
         big_run = ($urandom_range(0, 3) == 0);
      end
      req_bus.valid <= 1'b0;
      sender_steady = 1'b0;
      // let the monitor note the last accepted beat first
      @(posedge clock);

      while (tracker.expected_replies.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.expected_replies.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
